[hdl/ddmc_pkg.sv]
package ddmc_pkg;

  localparam int CmdW = 2;
  localparam int HeadW = 15;
  localparam int PulseW = 12;
  localparam int RegW = 21;
  localparam int BrakeW = 23;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ROTATE = 2'd1;
  localparam logic [1:0] CMD_DRIVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_MAX_ROT = 3'd0;
  localparam logic [2:0] REG_DRIVE_MAX = 3'd1;
  localparam logic [2:0] REG_BRAKE_DIST = 3'd2;
  localparam logic [2:0] REG_ACCEL = 3'd3;
  localparam logic [2:0] REG_BRAKE_STEP = 3'd4;

  localparam int PiQ12 = 12868;
  localparam int QuarterPiQ12 = 3217;
  localparam int ThreeQuarterPiQ12 = 9651;
  localparam int AlignQ12 = 205;
  localparam int ArriveQ16 = 656;
  localparam longint LOffQ16 = 64'd98094285;
  localparam longint LGainQ16 = 64'd38450627;
  localparam longint ROffQ16 = 64'd98172928;
  localparam longint RGainQ16 = 64'd38818284;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_PULSE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic apply;
    logic pulse;
  } ctrl_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } stat_t;

endpackage

[hdl/ddmc_if.sv]
interface ddmc_in_if #(parameter int POS_WIDTH = 24);
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic signed [14:0] heading;
  logic signed [14:0] target_heading;
  logic signed [POS_WIDTH-1:0] pos_x;
  logic signed [POS_WIDTH-1:0] pos_y;
  logic signed [POS_WIDTH-1:0] goal_x;
  logic signed [POS_WIDTH-1:0] goal_y;
  logic backward;
  modport source(output valid, cmd, heading, target_heading, pos_x, pos_y, goal_x, goal_y,
                 backward, input ready);
  modport sink(input valid, cmd, heading, target_heading, pos_x, pos_y, goal_x, goal_y,
               backward, output ready);
endinterface

interface ddmc_out_if;
  logic valid;
  logic ready;
  logic done_res;
  logic [11:0] left_pulse;
  logic [11:0] right_pulse;
  modport source(output valid, done_res, left_pulse, right_pulse, input ready);
  modport sink(input valid, done_res, left_pulse, right_pulse, output ready);
endinterface

[hdl/ddmc_ctrl.sv]
module ddmc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ddmc_pkg::stat_t stat,
  output ddmc_pkg::ctrl_t ctrl
);
  import ddmc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.prep = 1'b1;
        state_next = stat.need_div ? ST_DIV : ST_APPLY;
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        ctrl.apply = 1'b1;
        state_next = ST_PULSE;
      end
      ST_PULSE: begin
        ctrl.pulse = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

[hdl/ddmc_dp.sv]
module ddmc_dp #(
  parameter int SPEED_WIDTH = 24,
  parameter int POS_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  ddmc_pkg::ctrl_t ctrl,
  output ddmc_pkg::stat_t stat,
  input  logic [1:0] cmd,
  input  logic signed [14:0] heading,
  input  logic signed [14:0] target_heading,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] goal_x,
  input  logic signed [POS_WIDTH-1:0] goal_y,
  input  logic backward,
  input  logic [20:0] max_rot,
  input  logic [20:0] drive_max,
  input  logic [22:0] brake_dist,
  input  logic [20:0] accel_step,
  input  logic [20:0] brake_step,
  output logic done_res,
  output logic [11:0] left_pulse,
  output logic [11:0] right_pulse
);
  import ddmc_pkg::*;

  localparam int DW = POS_WIDTH + 1;
  localparam int NW = DW + 21;
  localparam int CW = $clog2(NW + 1);
  localparam int SW = SPEED_WIDTH;
  localparam int EW = (SW > 22 ? SW : 22) + 2;
  localparam logic signed [EW-1:0] SpdHi = EW'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [EW-1:0] SpdLo = -SpdHi - EW'(1);

  // input item latches
  logic [1:0] cmd_r;
  logic signed [14:0] head_r, thead_r;
  logic signed [POS_WIDTH-1:0] px_r, py_r, gx_r, gy_r;
  logic back_r;

  logic signed [SW-1:0] left_target, right_target, left_speed, right_speed;

  // prep results
  logic signed [16:0] err;
  logic signed [DW-1:0] drive_d;
  logic upd;
  logic done_r;
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [NW:0] rem;
  logic [CW-1:0] cnt;

  // combinational prep
  logic signed [16:0] err_raw, err_w;
  logic signed [DW-1:0] dx, dy, dsel;
  logic [DW-1:0] dxm, dym, dmag;
  logic [16:0] ahm;
  logic p_upd, p_done, p_drive;
  logic [NW-1:0] p_num;

  always_comb begin
    err_raw = 17'(thead_r) - 17'(head_r);
    if (err_raw > 17'sd12868) err_w = err_raw - 17'sd25736;
    else if (err_raw < -17'sd12868) err_w = err_raw + 17'sd25736;
    else err_w = err_raw;
    dx = DW'(gx_r) - DW'(px_r);
    dy = DW'(gy_r) - DW'(py_r);
    dxm = dx[DW-1] ? DW'(-dx) : DW'(dx);
    dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
    ahm = head_r[14] ? 17'(-17'(head_r)) : 17'(head_r);
    p_upd = 1'b0;
    p_done = 1'b0;
    p_drive = 1'b0;
    dsel = dy;
    if (cmd_r == CMD_ROTATE) begin
      p_upd = 1'b1;
      p_done = ((err_w[16] ? -err_w : err_w) < 17'sd205);
    end else if (cmd_r == CMD_DRIVE) begin
      if (dxm < DW'(ArriveQ16) && dym < DW'(ArriveQ16)) begin
        p_upd = 1'b1;
        p_done = 1'b1;
      end else if (ahm < 17'(QuarterPiQ12)) begin
        p_upd = 1'b1;
        p_drive = 1'b1;
      end else if (ahm < 17'(ThreeQuarterPiQ12)) begin
        dsel = dx;
        if (!dx[DW-1] && dx != '0) begin
          p_upd = !head_r[14] && head_r != '0;
        end else begin
          p_upd = back_r;
        end
        p_drive = p_upd;
      end
    end
    dmag = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
    p_num = '0;
    if (p_drive) p_num = NW'(dmag) * NW'(drive_max);
  end

  // divisor: drive uses braking distance (zero as one); rotate divides by pi in Q12, on a numerator shifted left by two
  logic [22:0] divisor;
  logic is_rot;
  assign is_rot = (cmd_r == CMD_ROTATE);
  always_comb begin
    if (is_rot) divisor = 23'(PiQ12);
    else divisor = (brake_dist == '0) ? 23'd1 : brake_dist;
  end

  logic [NW:0] rem_sh;
  assign rem_sh = {rem[NW-1:0], num[NW-1]};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= cmd;
      head_r <= heading;
      thead_r <= target_heading;
      px_r <= pos_x;
      py_r <= pos_y;
      gx_r <= goal_x;
      gy_r <= goal_y;
      back_r <= backward;
    end
    if (ctrl.prep) begin
      err <= err_w;
      drive_d <= dsel;
      upd <= p_upd;
      done_r <= p_done;
      if (cmd_r == CMD_ROTATE)
        num <= NW'(err_w[16] ? 17'(-err_w) : 17'(err_w)) * NW'(max_rot) << 2;
      else
        num <= p_num;
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end
    if (ctrl.div_step) begin
      if (rem_sh >= (NW+1)'(divisor)) begin
        rem <= rem_sh - (NW+1)'(divisor);
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
      num <= num << 1;
      cnt <= cnt + CW'(1);
    end
  end

  assign stat.need_div = p_drive || (cmd_r == CMD_ROTATE);
  assign stat.div_last = (cnt == CW'(NW - 1));

  // apply: cap, sign, saturate
  logic [NW-1:0] cap;
  logic [NW-1:0] capped;
  logic signed [EW-1:0] sv, sat_pos, sat_neg;
  always_comb begin
    cap = is_rot ? NW'(max_rot) : NW'(drive_max);
    capped = (quo > cap) ? cap : quo;
    sv = EW'(capped);
    sat_pos = (sv > SpdHi) ? SpdHi : sv;
    sat_neg = (-sv < SpdLo) ? SpdLo : -sv;
  end

  // slew
  function automatic logic signed [SW-1:0] slew(input logic signed [SW-1:0] cur,
                                                 input logic signed [SW-1:0] tgt,
                                                 input logic [20:0] acc,
                                                 input logic [20:0] brk);
    logic [SW:0] mt, mc;
    logic signed [EW-1:0] step, c, r;
    mt = tgt[SW-1] ? (SW+1)'(-(SW+1)'(tgt)) : (SW+1)'(tgt);
    mc = cur[SW-1] ? (SW+1)'(-(SW+1)'(cur)) : (SW+1)'(cur);
    step = (mt < mc) ? EW'(brk) : EW'(acc);
    c = EW'(cur);
    if (tgt > cur) begin
      r = c + step;
      if (EW'(tgt) < r) r = EW'(tgt);
    end else begin
      r = c - step;
      if (EW'(tgt) > r) r = EW'(tgt);
    end
    if (r > SpdHi) r = SpdHi;
    else if (r < SpdLo) r = SpdLo;
    return SW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      left_target <= '0;
      right_target <= '0;
      left_speed <= '0;
      right_speed <= '0;
    end else if (ctrl.apply) begin
      if (cmd_r == CMD_TICK) begin
        left_speed <= slew(left_speed, left_target, accel_step, brake_step);
        right_speed <= slew(right_speed, right_target, accel_step, brake_step);
      end else if (upd) begin
        if (done_r && cmd_r == CMD_DRIVE) begin
          left_target <= '0;
          right_target <= '0;
        end else if (is_rot) begin
          right_target <= (err > 0) ? SW'(sat_pos) : SW'(sat_neg);
          left_target <= (err > 0) ? SW'(sat_neg) : SW'(sat_pos);
        end else begin
          left_target <= drive_d[DW-1] ? SW'(sat_neg) : SW'(sat_pos);
          right_target <= drive_d[DW-1] ? SW'(sat_neg) : SW'(sat_pos);
        end
      end
    end
  end

  // pulse widths, one multiply per wheel
  localparam int PW = SW + 60;
  logic signed [PW-1:0] lp, rp;
  always_ff @(posedge clk) begin
    if (ctrl.pulse) begin
      lp <= (PW'(LOffQ16) <<< 20) - PW'(LGainQ16) * PW'(left_speed);
      rp <= (PW'(ROffQ16) <<< 20) + PW'(RGainQ16) * PW'(right_speed);
      done_res <= done_r && (cmd_r == CMD_ROTATE || cmd_r == CMD_DRIVE);
    end
  end

  function automatic logic [11:0] to_pulse(input logic signed [PW-1:0] q);
    logic signed [PW-1:0] p;
    p = q >>> 36;
    if (q < 0) return 12'd0;
    if (p > PW'(4095)) return 12'd4095;
    return p[11:0];
  endfunction

  assign left_pulse = to_pulse(lp);
  assign right_pulse = to_pulse(rp);
endmodule

[hdl/differential_drive_motion_controller.sv]
// Differential drive motion controller.
// Channels: in_ch (sink) carries cmd and pose; out_ch (source) carries
// done_res and the two servo pulse widths. One result per transfer in.
// APB port writes the five motion registers at byte address 4*i; pready is
// always high and reads return the register value.
// Ticks, and drives that zero or keep the targets, skip the divider and go
// from PREP through APPLY and PULSE to OUT.
// Rotate and other drive commands run a restoring divider, one quotient bit
// per cycle over POS_WIDTH+22 bits, between PREP and APPLY.
// One item is in flight at a time; in_ch.ready is high only when idle, so the
// next item can be taken in the cycle after the result transfers.
// Reset clears all targets and speeds and loads the register reset values.
// While the receiver stalls, the result holds on out_ch and no new item is
// taken until the result transfers.
module differential_drive_motion_controller #(
  parameter int SPEED_WIDTH = 24,
  parameter int POS_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  ddmc_in_if.sink in_ch,
  ddmc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import ddmc_pkg::*;

  logic [20:0] max_rot, drive_max, accel_step, brake_step;
  logic [22:0] brake_dist;
  ctrl_t ctrl;
  stat_t stat;

  assign pready = 1'b1;

  // register file writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rot <= 21'd524288;
      drive_max <= 21'd1048576;
      brake_dist <= 23'd6554;
      accel_step <= 21'd105;
      brake_step <= 21'd210;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_MAX_ROT: max_rot <= pwdata[20:0];
        REG_DRIVE_MAX: drive_max <= pwdata[20:0];
        REG_BRAKE_DIST: brake_dist <= pwdata[22:0];
        REG_ACCEL: accel_step <= pwdata[20:0];
        REG_BRAKE_STEP: brake_step <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MAX_ROT: prdata = 32'(max_rot);
      REG_DRIVE_MAX: prdata = 32'(drive_max);
      REG_BRAKE_DIST: prdata = 32'(brake_dist);
      REG_ACCEL: prdata = 32'(accel_step);
      REG_BRAKE_STEP: prdata = 32'(brake_step);
      default: prdata = '0;
    endcase
  end

  ddmc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .ctrl(ctrl)
  );

  ddmc_dp #(.SPEED_WIDTH(SPEED_WIDTH), .POS_WIDTH(POS_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cmd(in_ch.cmd), .heading(in_ch.heading), .target_heading(in_ch.target_heading),
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .goal_x(in_ch.goal_x), .goal_y(in_ch.goal_y),
    .backward(in_ch.backward),
    .max_rot(max_rot), .drive_max(drive_max), .brake_dist(brake_dist),
    .accel_step(accel_step), .brake_step(brake_step),
    .done_res(out_ch.done_res), .left_pulse(out_ch.left_pulse),
    .right_pulse(out_ch.right_pulse)
  );
endmodule

[hdl/ddmc_checker.sv]
module ddmc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [11:0] left_pulse
);
  // never take an item while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  // after an input transfer, no result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // after an output transfer the block is idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready) else $error("not idle after result");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(left_pulse)) else $error("pulse moved");
endmodule

bind differential_drive_motion_controller ddmc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .left_pulse(out_ch.left_pulse)
);
